FILE: hw/rtl/rhq_pkg.sv
// Shared types and constants for the round-half-even fixed-point quantizer.
// Used by the channel interfaces and by every module of the block.
package rhq_pkg;

    localparam int DW = 64;
    localparam int QW = 32;

    localparam logic [QW:0] LIMIT_POS = {2'b00, {(QW - 1){1'b1}}};
    localparam logic [QW:0] LIMIT_NEG = {2'b01, {(QW - 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [DW-2:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quot;
        logic [DW-2:0] den;
        logic          neg;
        t_status       status;
    } t_div_word;

    typedef struct packed {
        logic [QW-1:0] value;
        t_status       status;
    } t_result;

endpackage

FILE: hw/rtl/rhq_in_if.sv
// Input channel of the quantizer: valid, ready and one numerator/denominator item.
// Depends on rhq_pkg for the field widths.
interface rhq_in_if import rhq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] numerator;
    logic signed [DW-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink (input valid, input numerator, input denominator, output ready);

endinterface

FILE: hw/rtl/rhq_out_if.sv
// Output channel of the quantizer: valid, ready and one Q16.16 result item.
// Depends on rhq_pkg for the field widths.
interface rhq_out_if import rhq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] fixed_value;
    logic [1:0]           status;

    modport source (output valid, output fixed_value, output status, input ready);
    modport sink (input valid, input fixed_value, input status, output ready);

endinterface

FILE: hw/rtl/rhq_front.sv
// Front cells: takes the magnitude of the numerator, scales it and screens the
// item for bad denominators and overflow. Depends on rhq_pkg.
module rhq_front import rhq_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_numerator,
    input  logic signed [DW-1:0] i_denominator,
    output logic                 o_valid,
    output t_div_word            o_word
);

    logic          r_s1_valid;
    logic          r_s1_neg;
    logic          r_s1_invalid;
    logic [DW-1:0] r_s1_mag;
    logic [DW-2:0] r_s1_den;

    logic          n_s1_neg;
    logic          n_s1_invalid;
    logic [DW-1:0] n_s1_mag;

    logic          r_s2_valid;
    t_div_word     r_s2_word;
    t_div_word     n_s2_word;

    logic [DW-1:0] scaled;
    logic          mag_wide;
    logic          quot_big;

    always_comb begin
        n_s1_neg     = i_numerator[DW-1];
        n_s1_invalid = i_denominator[DW-1] || (i_denominator == '0);
        n_s1_mag     = n_s1_neg ? (~i_numerator + DW'(1)) : i_numerator;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_neg     <= n_s1_neg;
            r_s1_invalid <= n_s1_invalid;
            r_s1_mag     <= n_s1_mag;
            r_s1_den     <= i_denominator[DW-2:0];
            r_s2_word    <= n_s2_word;
        end
    end

    always_comb begin
        scaled   = r_s1_mag << FRACTION_BITS;
        mag_wide = (r_s1_mag >> (DW - FRACTION_BITS)) != '0;
        quot_big = DW'(scaled[DW-1:QW]) >= {1'b0, r_s1_den};

        n_s2_word.rem  = (DW-1)'(scaled[DW-1:QW]);
        n_s2_word.low  = scaled[QW-1:0];
        n_s2_word.quot = '0;
        n_s2_word.den  = r_s1_den;
        n_s2_word.neg  = r_s1_neg;
        if (r_s1_invalid) begin
            n_s2_word.status = ST_INVALID;
        end else if (mag_wide || quot_big) begin
            n_s2_word.status = ST_OVERFLOW;
        end else begin
            n_s2_word.status = ST_OK;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_word  = r_s2_word;

endmodule

FILE: hw/rtl/rhq_div_cell.sv
// One restoring-division cell: shifts in one dividend bit, subtracts the
// divisor when it fits and emits one quotient bit. Depends on rhq_pkg.
module rhq_div_cell import rhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_valid,
    output t_div_word o_word
);

    logic          r_valid;
    t_div_word     r_word;
    t_div_word     n_word;

    logic [DW-1:0] rem_ext;
    logic [DW-1:0] diff;
    logic          fits;

    always_comb begin
        rem_ext = {i_word.rem, i_word.low[QW-1]};
        diff    = rem_ext - {1'b0, i_word.den};
        fits    = rem_ext >= {1'b0, i_word.den};

        n_word      = i_word;
        n_word.rem  = fits ? diff[DW-2:0] : rem_ext[DW-2:0];
        n_word.low  = {i_word.low[QW-2:0], 1'b0};
        n_word.quot = {i_word.quot[QW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: hw/rtl/rhq_round.sv
// Rounding cell: rounds the quotient half to even, then checks the range and
// applies the numerator's sign. Depends on rhq_pkg.
module rhq_round import rhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_valid,
    output t_result   o_result
);

    logic          r_valid;
    logic [QW:0]   r_quot;
    logic          r_neg;
    t_status       r_status;

    logic [DW-1:0] twice;
    logic          round_up;
    logic [QW:0]   n_quot;
    logic [QW:0]   limit;
    logic          too_big;

    always_comb begin
        twice    = {i_word.rem, 1'b0};
        round_up = (twice > {1'b0, i_word.den}) ||
                   ((twice == {1'b0, i_word.den}) && i_word.quot[0]);
        n_quot   = {1'b0, i_word.quot} + (QW+1)'(round_up);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot   <= n_quot;
            r_neg    <= i_word.neg;
            r_status <= i_word.status;
        end
    end

    always_comb begin
        limit   = r_neg ? LIMIT_NEG : LIMIT_POS;
        too_big = r_quot > limit;
        o_result.value  = '0;
        o_result.status = r_status;
        if (r_status == ST_OK) begin
            if (too_big) begin
                o_result.status = ST_OVERFLOW;
            end else begin
                o_result.value = r_neg ? (QW'(0) - r_quot[QW-1:0]) : r_quot[QW-1:0];
            end
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/rhq_out_buf.sv
// Output register with a skid entry. Holds the chain of cells while the skid
// entry is occupied. Depends on rhq_pkg and rhq_out_if.
module rhq_out_buf import rhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_result   i_result,
    output logic      o_en,
    rhq_out_if.source o_out
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    take;
    logic    drain;

    assign o_en  = !r_skid_valid;
    assign take  = i_valid && !r_skid_valid;
    assign drain = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (drain) begin
            r_out_valid <= take;
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (drain) begin
            r_out <= i_result;
        end else begin
            r_skid <= i_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fixed_value = r_out.value;
    assign o_out.status      = r_out.status;

endmodule

FILE: hw/rtl/round_half_even_fixed_point_quantizer.sv
// Round-half-even fixed-point quantizer, top level.
// Each item on i_in carries a signed 64-bit numerator and denominator; each item
// on o_out carries numerator / denominator as a signed Q16.16 fixed_value and a
// status: ok, invalid argument (denominator not positive) or overflow.
// fixed_value is zero whenever status is not ok. Every input item gives exactly
// one result item, in order.
// Both channels use valid/ready; an item moves when both are high.
// The divider is a chain of 32 identical cells, one quotient bit per cell,
// between two front cells and one rounding cell; a new item enters every cycle
// while the skid entry is empty. Throughput is one item per cycle, set by the
// one-bit-per-cell chain, as long as o_out does not stall.
// When o_out stalls, the result waiting there holds and one more result goes
// into a skid entry; the whole chain then freezes and i_in.ready drops until
// the receiver takes an item.
// Reset is synchronous and active low; it empties every cell and both output
// entries. The block keeps no state between items.
module round_half_even_fixed_point_quantizer import rhq_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhq_in_if.sink    i_in,
    rhq_out_if.source o_out
);

    logic      w_en;
    logic      w_valid [0:QW];
    t_div_word w_word  [0:QW];
    logic      w_res_valid;
    t_result   w_result;

    assign i_in.ready = w_en;

    rhq_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_in.valid),
        .i_numerator   (i_in.numerator),
        .i_denominator (i_in.denominator),
        .o_valid       (w_valid[0]),
        .o_word        (w_word[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        rhq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_word  (w_word[g]),
            .o_valid (w_valid[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    rhq_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_valid[QW]),
        .i_word   (w_word[QW]),
        .o_valid  (w_res_valid),
        .o_result (w_result)
    );

    rhq_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .i_result (w_result),
        .o_en     (w_en),
        .o_out    (o_out)
    );

endmodule

FILE: verif/rhq_quotient_checker.sv
// Result checker for the round-half-even fixed-point quantizer.
// Watches both channels, predicts each Q16.16 quotient and compares it with the output.
// Depends on rhq_pkg and on the rhq_in_if and rhq_out_if channel interfaces.
`timescale 1ns / 1ps

module rhq_quotient_checker import rhq_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rhq_in_if    i_in,
    rhq_out_if   i_out,
    output int   o_pending,
    output int   o_mismatches
);

    t_result expected_results[$];
    t_result want;
    int      mismatch_count = 0;
    int      result_count = 0;

    function automatic t_result quantize_ratio(logic [DW-1:0] num, logic [DW-1:0] den);
        logic [DW-1:0] mag;
        logic [DW-1:0] scaled;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
        logic [DW-1:0] twice;
        logic [DW-1:0] ceiling;
        t_result       r;
        r.value  = '0;
        r.status = ST_OK;
        if (den[DW-1] || den == '0) begin
            r.status = ST_INVALID;
            return r;
        end
        mag = num[DW-1] ? (~num + 64'd1) : num;
        if (mag > ({DW{1'b1}} >> FRACTION_BITS)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        scaled = mag << FRACTION_BITS;
        quot = scaled / den;
        rem = scaled % den;
        twice = rem << 1;
        if (twice > den || (twice == den && quot[0])) begin
            quot = quot + 64'd1;
        end
        ceiling = num[DW-1] ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (quot > ceiling) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.value = num[DW-1] ? (32'd0 - quot[QW-1:0]) : quot[QW-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(quantize_ratio(i_in.numerator, i_in.denominator));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d", $time,
                             $signed(i_out.fixed_value), i_out.status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.fixed_value !== want.value || i_out.status !== want.status) begin
                        $display("%0t: result %0d expected value %0d status %0d, got value %0d status %0d",
                                 $time, result_count, $signed(want.value), want.status,
                                 $signed(i_out.fixed_value), i_out.status);
                        mismatch_count++;
                    end
                end
                result_count++;
            end
            o_pending <= expected_results.size();
            o_mismatches <= mismatch_count;
        end
    end

endmodule

FILE: verif/round_half_even_fixed_point_quantizer_tb.sv
// Testbench top for the round-half-even fixed-point quantizer.
// Drives directed and random ratios with bursty input and a stalling receiver.
// Depends on rhq_pkg, the channel interfaces, the block and rhq_quotient_checker.
`timescale 1ns / 1ps

module round_half_even_fixed_point_quantizer_tb;

    localparam int FRACTION_BITS = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 48;

    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_PERIODIC = 3;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   mismatches;
    int   burst_left = 0;
    int   rx_mode = RX_FREE;
    int   rx_left = 0;
    int   cycle_count = 0;

    rhq_in_if  in_ch ();
    rhq_out_if out_ch ();

    round_half_even_fixed_point_quantizer #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rhq_quotient_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) quotient_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
                rx_left = $urandom_range(20, 200);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_FREE: begin
                    out_ch.ready <= 1'b1;
                end
                RX_COIN: begin
                    out_ch.ready <= ($urandom_range(0, 1) == 1);
                end
                RX_SPARSE: begin
                    out_ch.ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    out_ch.ready <= (rx_left % 5 != 0);
                end
            endcase
        end
    end

    function automatic logic [63:0] random_bits(int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (w <= 0) begin
            return 64'd0;
        end
        if (w < 64) begin
            r = r & ((64'd1 << w) - 64'd1);
        end
        return r;
    endfunction

    task automatic send_ratio(input logic [63:0] num, input logic [63:0] den);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.numerator <= num;
        in_ch.denominator <= den;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    initial begin : stimulus
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] e;
        logic [63:0] q;
        int          kind;
        int          w;
        int          cap;

        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.numerator <= '0;
        in_ch.denominator <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_ratio(64'd1, 64'd1);
        send_ratio(-64'd1, 64'd1);
        send_ratio(64'd0, 64'd1);
        send_ratio(64'd5, 64'd0);
        send_ratio(64'd5, -64'd1);
        send_ratio(64'd5, 64'h8000_0000_0000_0000);
        send_ratio(64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
        send_ratio(64'h8000_0000_0000_0000, 64'd1);
        send_ratio(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_ratio(64'h0000_FFFF_FFFF_FFFF, 64'h0001_0000_0000_0000);
        send_ratio(-64'h0000_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_ratio(64'h0001_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_ratio(64'd32768, 64'd1);
        send_ratio(-64'd32768, 64'd1);
        send_ratio(64'd32767, 64'd1);
        send_ratio(64'd1, 64'h2_0000);
        send_ratio(64'd3, 64'h2_0000);
        send_ratio(-64'd1, 64'h2_0000);
        send_ratio(-64'd3, 64'h2_0000);
        send_ratio(64'd1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_ratio(64'hFFFF_FFFF, 64'h2_0000);
        send_ratio(-64'hFFFF_FFFF, 64'h2_0000);
        send_ratio(64'hFFFF_FFFD, 64'h2_0000);
        send_ratio(-64'h1_0000_0002, 64'h2_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                num = random_bits(64);
                den = random_bits(64);
            end else if (kind < 4) begin
                num = random_bits(64);
                den = ($urandom_range(0, 3) == 0) ? 64'd0 : {1'b1, random_bits(63)};
            end else if (kind < 5) begin
                num = (64'd1 << 48) - 64'($urandom_range(0, 2));
                den = random_bits($urandom_range(1, 63)) | 64'd1;
                if ($urandom_range(0, 1) == 1) begin
                    num = -num;
                end
            end else if (kind < 8) begin
                e = random_bits($urandom_range(0, 20)) | 64'd1;
                q = random_bits($urandom_range(0, 14));
                den = e << 17;
                num = ((q << 1) + 64'd1) * e;
                if ($urandom_range(0, 1) == 1) begin
                    num = -num;
                end
            end else begin
                w = $urandom_range(1, 63);
                den = random_bits(w);
                if (den == 64'd0) begin
                    den = 64'd1;
                end
                cap = (w + 15 > 48) ? 48 : w + 15;
                num = random_bits($urandom_range(0, cap));
                if ($urandom_range(0, 1) == 1) begin
                    num = -num;
                end
            end
            send_ratio(num, den);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rhq_pkg.sv
hw/rtl/rhq_in_if.sv
hw/rtl/rhq_out_if.sv
hw/rtl/rhq_front.sv
hw/rtl/rhq_div_cell.sv
hw/rtl/rhq_round.sv
hw/rtl/rhq_out_buf.sv
hw/rtl/round_half_even_fixed_point_quantizer.sv
verif/rhq_quotient_checker.sv
verif/round_half_even_fixed_point_quantizer_tb.sv
